>>> rtl/mfli_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfli_pkg
// Shared types and constants of the menu file line indexer: character codes,
// line and scan codes, microcode word layout and step addresses.
// ----------------------------------------------------------------------------
package mfli_pkg;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int CAP_DEPTH = 32;
    localparam int CAP_AW    = 5;

    localparam logic [1:0] LT_MENU   = 2'd0;
    localparam logic [1:0] LT_SLEEP  = 2'd1;
    localparam logic [1:0] LT_COLOR  = 2'd2;
    localparam logic [1:0] LT_IGNORE = 2'd3;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_SWALLOW = 2'd1;
    localparam logic [1:0] MODE_STOPPED = 2'd2;

    localparam logic [1:0] EMIT_NONE  = 2'd0;
    localparam logic [1:0] EMIT_ENTRY = 2'd1;
    localparam logic [1:0] EMIT_CHAR  = 2'd2;

    localparam logic [2:0] COND_NEVER   = 3'd0;
    localparam logic [2:0] COND_ALWAYS  = 3'd1;
    localparam logic [2:0] COND_NOFIN   = 3'd2;
    localparam logic [2:0] COND_MENU    = 3'd3;
    localparam logic [2:0] COND_NOCHARS = 3'd4;
    localparam logic [2:0] COND_MORE    = 3'd5;

    localparam logic [2:0] UPC_FETCH  = 3'd0;
    localparam logic [2:0] UPC_DECODE = 3'd1;
    localparam logic [2:0] UPC_LINE   = 3'd2;
    localparam logic [2:0] UPC_CHECK  = 3'd3;
    localparam logic [2:0] UPC_DREAD  = 3'd4;
    localparam logic [2:0] UPC_DEMIT  = 3'd5;
    localparam logic [2:0] UPC_END    = 3'd6;
    localparam logic [2:0] UPC_ENTRY  = 3'd7;

    typedef struct packed {
        logic       accept;
        logic       wait_out;
        logic [1:0] emit;
        logic       scan;
        logic       newline;
        logic       rd;
        logic       kclr;
        logic [2:0] cond;
        logic [2:0] target;
    } t_uword;

    typedef struct packed {
        logic finish;
        logic menu;
        logic nochars;
        logic more;
        logic out_free;
    } t_flags;

    typedef struct packed {
        logic        kind;
        logic [3:0]  entry_number;
        logic [15:0] entry_offset;
        logic [15:0] entry_size;
        logic        param_id;
        logic [4:0]  char_position;
        logic [7:0]  char_value;
        logic        run_end;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/mfli_useq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfli_useq
// Microcode sequencer: step counter, control store and conditional jumps.
// Action bits of the control word are masked while the step is stalled.
// ----------------------------------------------------------------------------
module mfli_useq
    import mfli_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    input  wire t_flags i_flags,
    output t_uword      o_ctl,
    output logic        o_ready
);

    function automatic t_uword rom(input logic [2:0] a);
        t_uword w;
        w = '0;
        case (a)
            UPC_FETCH: begin
                w.accept = 1'b1;
                w.cond   = COND_NEVER;
            end
            UPC_DECODE: begin
                w.scan   = 1'b1;
                w.cond   = COND_NOFIN;
                w.target = UPC_FETCH;
            end
            UPC_LINE: begin
                w.cond   = COND_MENU;
                w.target = UPC_ENTRY;
            end
            UPC_CHECK: begin
                w.kclr   = 1'b1;
                w.cond   = COND_NOCHARS;
                w.target = UPC_END;
            end
            UPC_DREAD: begin
                w.rd   = 1'b1;
                w.cond = COND_NEVER;
            end
            UPC_DEMIT: begin
                w.wait_out = 1'b1;
                w.emit     = EMIT_CHAR;
                w.cond     = COND_MORE;
                w.target   = UPC_DREAD;
            end
            UPC_END: begin
                w.newline = 1'b1;
                w.cond    = COND_ALWAYS;
                w.target  = UPC_FETCH;
            end
            UPC_ENTRY: begin
                w.wait_out = 1'b1;
                w.emit     = EMIT_ENTRY;
                w.cond     = COND_ALWAYS;
                w.target   = UPC_END;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = UPC_FETCH;
            end
        endcase
        return w;
    endfunction

    logic [2:0] r_upc;
    logic [2:0] n_upc;
    t_uword     c_word;
    logic       c_go;
    logic       c_take;

    assign c_word = rom(r_upc);
    assign c_go   = !(c_word.accept && !i_in_valid) && !(c_word.wait_out && !i_flags.out_free);

    always_comb begin
        case (c_word.cond)
            COND_NEVER:   c_take = 1'b0;
            COND_ALWAYS:  c_take = 1'b1;
            COND_NOFIN:   c_take = !i_flags.finish;
            COND_MENU:    c_take = i_flags.menu;
            COND_NOCHARS: c_take = i_flags.nochars;
            COND_MORE:    c_take = i_flags.more;
            default:      c_take = 1'b0;
        endcase
    end

    always_comb begin
        n_upc = r_upc;
        if (c_go) begin
            n_upc = c_take ? c_word.target : r_upc + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

    always_comb begin
        o_ctl = c_word;
        if (!c_go) begin
            o_ctl.accept  = 1'b0;
            o_ctl.emit    = EMIT_NONE;
            o_ctl.scan    = 1'b0;
            o_ctl.newline = 1'b0;
            o_ctl.rd      = 1'b0;
            o_ctl.kclr    = 1'b0;
        end
    end

    assign o_ready = c_word.accept;

`ifndef SYNTHESIS
    a_ready_only_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_upc == UPC_FETCH)
        else $error("ready outside the fetch step");
    a_emit_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.emit != EMIT_NONE |-> i_flags.out_free)
        else $error("result issued into a busy output register");
    a_fetch_follows_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UPC_END) |=> r_upc == UPC_FETCH)
        else $error("end step not followed by fetch");
`endif

endmodule
`default_nettype wire

>>> rtl/mfli_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfli_dpath
// Datapath: line and capture state, capture buffer memory, output register.
// Each action bit of the control word triggers one operation on the registers.
// ----------------------------------------------------------------------------
module mfli_dpath
    import mfli_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int SLEEP_LEN   = 4,
    parameter int COLOR_LEN   = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_uword     i_ctl,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_fin,
    input  wire logic       i_out_ready,
    output t_flags          o_flags,
    output logic            o_out_valid,
    output t_result         o_out
);

    logic [7:0]        r_byte;
    logic              r_fin;
    logic [15:0]       r_off;
    logic [15:0]       r_lbeg;
    logic [15:0]       r_lcnt;
    logic [4:0]        r_nent;
    logic [1:0]        r_lt;
    logic [1:0]        r_mode;
    logic              r_open;
    logic [CAP_AW-1:0] r_cnt;
    logic [CAP_AW-1:0] r_k;
    logic [7:0]        r_rdata;
    logic              r_ovalid;
    t_result           r_out;
    t_result           n_out;
    logic [7:0]        r_mem [CAP_DEPTH];

    logic              c_finish;
    logic              c_cap_line;
    logic [CAP_AW-1:0] c_limit;
    logic [CAP_AW:0]   c_knext;
    logic              c_do_scan;
    logic              c_store;

    assign c_finish   = (r_mode == MODE_SWALLOW) || (r_mode == MODE_NORMAL && r_byte == CH_LF);
    assign c_cap_line = (r_lt == LT_SLEEP) || (r_lt == LT_COLOR);
    assign c_limit    = (r_lt == LT_SLEEP) ? CAP_AW'(SLEEP_LEN - 1) : CAP_AW'(COLOR_LEN - 1);
    assign c_knext    = {1'b0, r_k} + (CAP_AW+1)'(1);
    assign c_do_scan  = i_ctl.scan && !c_finish;
    assign c_store    = c_do_scan && r_mode == MODE_NORMAL && r_byte != CH_CR
                        && r_lcnt >= 16'd3 && r_open && c_cap_line
                        && !(r_byte inside {CH_HASH, CH_SPACE} || r_cnt >= c_limit);

    assign o_flags.finish   = c_finish;
    assign o_flags.menu     = (r_lt == LT_MENU);
    assign o_flags.nochars  = !c_cap_line || r_cnt == '0;
    assign o_flags.more     = c_knext < {1'b0, r_cnt};
    assign o_flags.out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (c_store) begin
            r_mem[r_cnt] <= r_byte;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[r_k];
        end
        if (i_ctl.accept) begin
            r_byte <= i_byte;
            r_fin  <= i_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= '0;
            r_lbeg <= '0;
            r_lcnt <= '0;
            r_nent <= 5'd1;
            r_lt   <= LT_MENU;
            r_mode <= MODE_NORMAL;
            r_open <= 1'b0;
            r_cnt  <= '0;
            r_k    <= '0;
        end else if ((c_do_scan || i_ctl.newline) && r_fin) begin
            // drop all file state after the last byte
            r_off  <= '0;
            r_lbeg <= '0;
            r_lcnt <= '0;
            r_nent <= 5'd1;
            r_lt   <= LT_MENU;
            r_mode <= MODE_NORMAL;
            r_open <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (c_do_scan) begin
                if (r_mode == MODE_NORMAL) begin
                    if (r_byte == CH_CR) begin
                        r_mode <= MODE_SWALLOW;
                    end else begin
                        if (r_lcnt == 16'd0 && r_byte == CH_HASH) begin
                            r_lt <= LT_IGNORE;
                        end else if (r_lcnt == 16'd1 && r_lt == LT_IGNORE) begin
                            if (r_byte == CH_ONE) begin
                                r_lt   <= LT_SLEEP;
                                r_open <= 1'b1;
                            end else if (r_byte == CH_TWO) begin
                                r_lt   <= LT_COLOR;
                                r_open <= 1'b1;
                            end
                        end else if (r_lcnt >= 16'd3 && r_open && c_cap_line) begin
                            if (c_store) begin
                                r_cnt <= r_cnt + CAP_AW'(1);
                            end else begin
                                r_open <= 1'b0;
                            end
                        end
                        if (r_lcnt != 16'hFFFF) begin
                            r_lcnt <= r_lcnt + 16'd1;
                        end
                    end
                end
                r_off <= r_off + 16'd1;
            end
            if (i_ctl.newline) begin
                r_lbeg <= r_off + 16'd1;
                r_lcnt <= '0;
                r_lt   <= LT_MENU;
                r_open <= 1'b0;
                r_cnt  <= '0;
                r_mode <= (r_nent >= 5'(MAX_ENTRIES)) ? MODE_STOPPED : MODE_NORMAL;
                r_off  <= r_off + 16'd1;
            end
            if (i_ctl.emit == EMIT_ENTRY) begin
                r_nent <= r_nent + 5'd1;
            end
            if (i_ctl.kclr) begin
                r_k <= '0;
            end else if (i_ctl.emit == EMIT_CHAR) begin
                r_k <= c_knext[CAP_AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.emit != EMIT_NONE) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_comb begin
        n_out = r_out;
        case (i_ctl.emit)
            EMIT_ENTRY: begin
                n_out              = '0;
                n_out.entry_number = r_nent[3:0];
                n_out.entry_offset = r_lbeg;
                n_out.entry_size   = r_lcnt;
                n_out.run_end      = 1'b1;
            end
            EMIT_CHAR: begin
                n_out               = '0;
                n_out.kind          = 1'b1;
                n_out.param_id      = r_lt[1];
                n_out.char_position = r_k;
                n_out.char_value    = r_rdata;
                n_out.run_end       = (c_knext == {1'b0, r_cnt});
            end
            default: begin
                n_out = r_out;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_stop_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_STOPPED |-> r_nent >= 5'(MAX_ENTRIES))
        else $error("stopped below the entry limit");
    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_AW'(COLOR_LEN - 1) || r_cnt <= CAP_AW'(SLEEP_LEN - 1))
        else $error("capture count beyond limit");
    a_drain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.emit == EMIT_CHAR |-> r_k < r_cnt)
        else $error("drain index past capture count");
`endif

endmodule
`default_nettype wire

>>> rtl/menu_file_line_indexer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// menu_file_line_indexer_unit
// Splits a menu text file into lines, reports entry records and captured
// parameter characters.
// ----------------------------------------------------------------------------
// A microcode sequencer steps a small datapath through each byte. A body
// byte or a CR passes the fetch and decode steps. A byte that closes a
// line goes on through the line step, then the entry step for an entry line
// or the check step for an ignored, sleep or color line, then the end step.
// The capture buffer memory is read once per captured character, in a read
// step before the character is sent; output backpressure can stall the entry
// and character sends. Results are held in an output register, one per
// transfer, with tlast on the last result caused by a byte. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module menu_file_line_indexer_unit
    import mfli_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int SLEEP_LEN   = 4,
    parameter int COLOR_LEN   = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // data_byte
    input  wire logic        i_s_axis_tlast,   // final_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // entry_number[3:0], entry_offset[19:4], entry_size[35:20],
    // char_position[40:36], char_value[48:41], zeros above
    output logic [55:0]      o_m_axis_tdata,
    output logic [1:0]       o_m_axis_tuser,   // kind[0], param_id[1]
    output logic             o_m_axis_tlast    // run_end
);

    t_uword  w_ctl;
    t_flags  w_flags;
    t_result w_res;
    logic    w_ready;

    mfli_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_flags    (w_flags),
        .o_ctl      (w_ctl),
        .o_ready    (w_ready)
    );

    mfli_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SLEEP_LEN   (SLEEP_LEN),
        .COLOR_LEN   (COLOR_LEN)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_byte      (i_s_axis_tdata),
        .i_fin       (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_flags     (w_flags),
        .o_out_valid (o_m_axis_tvalid),
        .o_out       (w_res)
    );

    assign o_s_axis_tready = w_ready;
    assign o_m_axis_tdata  = {7'd0, w_res.char_value, w_res.char_position,
                              w_res.entry_size, w_res.entry_offset, w_res.entry_number};
    assign o_m_axis_tuser  = {w_res.param_id, w_res.kind};
    assign o_m_axis_tlast  = w_res.run_end;

endmodule
`default_nettype wire
